### hw/rtl/imu_frame_scale_integrate_unit_defines.svh
// assertion macros for the imu frame scale and integrate block
// expects clk and arst_n in the scope where a macro is used
`ifndef IMU_FRAME_SCALE_INTEGRATE_UNIT_DEFINES_SVH
`define IMU_FRAME_SCALE_INTEGRATE_UNIT_DEFINES_SVH

// checked only while out of reset
`define IFSI_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define IFSI_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/ifsi_pkg.sv
// shared widths and register codes for the imu frame scale and integrate block
// no dependencies
`default_nettype none

package ifsi_pkg;

	localparam int RAW_W      = 16;
	localparam int STAMP_W    = 24;
	localparam int SCALED_W   = 28;
	localparam int ANGLE_OUT_W = 48;
	localparam int ANGLE_BITS = 48;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int ACC_CODE_W = 2;
	localparam int GYR_CODE_W = 3;
	localparam int GRAV_W     = 20;
	localparam int TICK_W     = 32;

	localparam logic [CFG_IDX_W-1:0] REG_ACC_RANGE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GYRO_RANGE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GRAVITY    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TICK       = 2'd3;

	localparam logic KIND_ACCEL = 1'b0;
	localparam logic KIND_GYRO  = 1'b1;

endpackage

`default_nettype wire

### hw/rtl/ifsi_if.sv
// valid/ready channels for sensor frames in and scaled results out
// depends on ifsi_pkg
`default_nettype none

interface ifsi_frame_if import ifsi_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      action;
	logic signed [RAW_W-1:0]   raw_x;
	logic signed [RAW_W-1:0]   raw_y;
	logic signed [RAW_W-1:0]   raw_z;
	logic [STAMP_W-1:0]        stamp;

	modport source (output valid, action, raw_x, raw_y, raw_z, stamp, input ready);
	modport sink (input valid, action, raw_x, raw_y, raw_z, stamp, output ready);
endinterface

interface ifsi_result_if import ifsi_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic                          kind;
	logic signed [SCALED_W-1:0]    scaled_x;
	logic signed [SCALED_W-1:0]    scaled_y;
	logic signed [SCALED_W-1:0]    scaled_z;
	logic signed [ANGLE_OUT_W-1:0] angle_x;
	logic signed [ANGLE_OUT_W-1:0] angle_y;
	logic signed [ANGLE_OUT_W-1:0] angle_z;
	logic [STAMP_W-1:0]            delta_ticks;

	modport source (output valid, kind, scaled_x, scaled_y, scaled_z,
		angle_x, angle_y, angle_z, delta_ticks, input ready);
	modport sink (input valid, kind, scaled_x, scaled_y, scaled_z,
		angle_x, angle_y, angle_z, delta_ticks, output ready);
endinterface

`default_nettype wire

### hw/rtl/imu_frame_scale_integrate_unit.sv
// imu frame scaling and gyro angle integration, top level
// depends on ifsi_pkg, ifsi_if and imu_frame_scale_integrate_unit_defines.svh
`default_nettype none

// Accelerometer frames come out in Q16 m/s^2 (raw * range * gravity / 32768, rounded half up)
// and update the sensor time stamps; gyro frames come out in Q16 deg/s and add
// rate * delta_ticks * tick period to three 48-bit saturating angle accumulators. All
// products go through one shared 28 x 8 bit digit-serial multiplier that takes one
// byte of the multiplier per cycle: an accelerometer frame spends a load step, four digits
// and a rounding step per axis; a gyro frame first works the four-digit tick product
// (a load step, four digits and a finishing step) and then a load step, seven digits,
// a rounding step and an accumulate step per axis. One frame is worked at a time and
// the input is ready again in the cycle after the result is loaded. The result sits in
// an output register, so the next frame is taken while the previous result waits.
module imu_frame_scale_integrate_unit import ifsi_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	ifsi_frame_if.sink            frame,
	ifsi_result_if.source         result
);

	`include "imu_frame_scale_integrate_unit_defines.svh"

	localparam int AXES      = 3;
	localparam int AXIS_W    = 2;
	localparam int DIGIT_W   = 8;
	localparam int TQ_W      = STAMP_W + TICK_W;
	localparam int MCAND_W   = SCALED_W;
	localparam int MACC_W    = MCAND_W + DIGIT_W + 1;
	localparam int KFAC_W    = GRAV_W + 5;
	localparam int R125_W    = RAW_W + 8;
	localparam int INC_W     = 53;
	localparam int CNT_W     = 3;
	localparam int SUM_W     = (ANGLE_BITS > INC_W ? ANGLE_BITS : INC_W) + 1;

	localparam logic [CNT_W-1:0] ACC_DIGITS  = CNT_W'(4);
	localparam logic [CNT_W-1:0] TICK_DIGITS = CNT_W'(TICK_W / DIGIT_W);
	localparam logic [CNT_W-1:0] GYRO_DIGITS = CNT_W'(TQ_W / DIGIT_W);
	localparam logic [AXIS_W-1:0] LAST_AXIS  = AXIS_W'(AXES - 1);

	localparam logic signed [SUM_W-1:0] ANG_MAX =
		{{(SUM_W - ANGLE_BITS + 1){1'b0}}, {(ANGLE_BITS - 1){1'b1}}};
	localparam logic signed [SUM_W-1:0] ANG_MIN = ~ANG_MAX;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_START = 3'd1;
	localparam logic [2:0] ST_MUL   = 3'd2;
	localparam logic [2:0] ST_FIN   = 3'd3;
	localparam logic [2:0] ST_ACC   = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	localparam logic [1:0] OP_ACCEL = 2'd0;
	localparam logic [1:0] OP_TICKS = 2'd1;
	localparam logic [1:0] OP_GYRO  = 2'd2;

	function automatic logic signed [SCALED_W-1:0] gyro_scale(
		input logic signed [RAW_W-1:0] raw,
		input logic [GYR_CODE_W-1:0] code
	);
		logic signed [R125_W-1:0]   r;
		logic signed [SCALED_W-1:0] rw;
		r  = (R125_W'(raw) <<< 7) - (R125_W'(raw) <<< 2) + R125_W'(raw);
		rw = SCALED_W'(r);
		case (code)
			3'd0:    gyro_scale = rw <<< 5;
			3'd1:    gyro_scale = rw <<< 4;
			3'd2:    gyro_scale = rw <<< 3;
			3'd3:    gyro_scale = rw <<< 2;
			default: gyro_scale = rw <<< 1;
		endcase
	endfunction

	// range times gravity, range is 3 << code
	function automatic logic [KFAC_W-1:0] accel_factor(
		input logic [GRAV_W-1:0] grav,
		input logic [ACC_CODE_W-1:0] code
	);
		logic [GRAV_W+1:0] g3;
		g3 = (GRAV_W+2)'(grav) + ((GRAV_W+2)'(grav) << 1);
		accel_factor = KFAC_W'(g3) << code;
	endfunction

	logic [ACC_CODE_W-1:0] acc_range_q;
	logic [GYR_CODE_W-1:0] gyro_range_q;
	logic [GRAV_W-1:0]     gravity_q;
	logic [TICK_W-1:0]     tick_q;

	logic [STAMP_W-1:0] cur_time_q;
	logic [STAMP_W-1:0] prev_time_q;
	logic               time_unset_q;
	logic signed [ANGLE_BITS-1:0] ang_q [AXES];

	logic [2:0]        state_q;
	logic [1:0]        op_q;
	logic [AXIS_W-1:0] axis_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              out_valid_q;

	logic                       kind_q;
	logic signed [RAW_W-1:0]    raw_q [AXES];
	logic signed [SCALED_W-1:0] scaled_q [AXES];
	logic [STAMP_W-1:0]         delta_q;
	logic [TQ_W-1:0]            tq_q;
	logic signed [INC_W-1:0]    inc_q;

	logic signed [MCAND_W-1:0] mcand_q;
	logic [TQ_W-1:0]           mplier_q;
	logic signed [MACC_W-1:0]  macc_q;
	logic [TQ_W-1:0]           mlo_q;

	logic                          out_kind_q;
	logic signed [SCALED_W-1:0]    out_scaled_q [AXES];
	logic signed [ANGLE_OUT_W-1:0] out_ang_q [AXES];
	logic [STAMP_W-1:0]            out_delta_q;

	logic                       accept;
	logic                       load_out;
	logic signed [MACC_W-1:0]   mul_sum;
	logic signed [SUM_W-1:0]    ang_sum;
	logic signed [ANGLE_BITS-1:0] ang_next;
	logic signed [SCALED_W-1:0] accel_round;
	logic signed [SCALED_W-1:0] gyro_rate;

	assign accept   = frame.valid && frame.ready;
	assign load_out = (state_q == ST_DONE) && (!out_valid_q || result.ready);

	// one digit of the multiplier per cycle, low byte retires into mlo_q
	assign mul_sum = macc_q + mcand_q * $signed({1'b0, mplier_q[DIGIT_W-1:0]});

	assign accel_round = $signed({macc_q[10:0], mlo_q[55:39]}) + SCALED_W'(mlo_q[38]);
	assign gyro_rate   = gyro_scale(raw_q[0], gyro_range_q);

	always_comb begin
		ang_sum = SUM_W'(ang_q[axis_q]) + SUM_W'(inc_q);
		if (ang_sum > ANG_MAX) begin
			ang_next = ANGLE_BITS'(ANG_MAX);
		end else if (ang_sum < ANG_MIN) begin
			ang_next = ANGLE_BITS'(ANG_MIN);
		end else begin
			ang_next = ANGLE_BITS'(ang_sum);
		end
	end

	assign frame.ready = (state_q == ST_IDLE);

	// control, configuration and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_range_q  <= ACC_CODE_W'(1);
			gyro_range_q <= '0;
			gravity_q    <= GRAV_W'(642689);
			tick_q       <= TICK_W'(167772);
			cur_time_q   <= '0;
			prev_time_q  <= '0;
			time_unset_q <= 1'b1;
			for (int i = 0; i < AXES; i++) begin
				ang_q[i] <= '0;
			end
			state_q     <= ST_IDLE;
			op_q        <= OP_ACCEL;
			axis_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ACC_RANGE:  acc_range_q  <= cfg_wdata[ACC_CODE_W-1:0];
					REG_GYRO_RANGE: gyro_range_q <= cfg_wdata[GYR_CODE_W-1:0];
					REG_GRAVITY:    gravity_q    <= cfg_wdata[GRAV_W-1:0];
					REG_TICK:       tick_q       <= cfg_wdata[TICK_W-1:0];
					default: ;
				endcase
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						axis_q  <= '0;
						state_q <= ST_START;
						if (frame.action == KIND_ACCEL) begin
							prev_time_q  <= time_unset_q ? frame.stamp : cur_time_q;
							cur_time_q   <= frame.stamp;
							time_unset_q <= 1'b0;
							op_q         <= OP_ACCEL;
						end else begin
							op_q <= OP_TICKS;
						end
					end
				end
				ST_START: begin
					state_q <= ST_MUL;
					unique case (op_q)
						OP_ACCEL: cnt_q <= ACC_DIGITS - 1'b1;
						OP_TICKS: cnt_q <= TICK_DIGITS - 1'b1;
						default:  cnt_q <= GYRO_DIGITS - 1'b1;
					endcase
				end
				ST_MUL: begin
					if (cnt_q == '0) begin
						state_q <= ST_FIN;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_FIN: begin
					unique case (op_q)
						OP_TICKS: begin
							op_q    <= OP_GYRO;
							state_q <= ST_START;
						end
						OP_ACCEL: begin
							if (axis_q == LAST_AXIS) begin
								state_q <= ST_DONE;
							end else begin
								axis_q  <= axis_q + 1'b1;
								state_q <= ST_START;
							end
						end
						default: state_q <= ST_ACC;
					endcase
				end
				ST_ACC: begin
					ang_q[axis_q] <= ang_next;
					if (axis_q == LAST_AXIS) begin
						state_q <= ST_DONE;
					end else begin
						axis_q  <= axis_q + 1'b1;
						state_q <= ST_START;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= frame.action;
			raw_q[0] <= frame.raw_x;
			raw_q[1] <= frame.raw_y;
			raw_q[2] <= frame.raw_z;
			if (frame.action == KIND_ACCEL) begin
				delta_q <= time_unset_q ? '0 : frame.stamp - cur_time_q;
			end else begin
				delta_q <= cur_time_q - prev_time_q;
			end
		end

		if (state_q == ST_START) begin
			macc_q <= '0;
			unique case (op_q)
				OP_ACCEL: begin
					mcand_q  <= MCAND_W'(raw_q[0]);
					mplier_q <= TQ_W'(accel_factor(gravity_q, acc_range_q));
				end
				OP_TICKS: begin
					mcand_q  <= $signed({{(MCAND_W - STAMP_W){1'b0}}, delta_q});
					mplier_q <= TQ_W'(tick_q);
				end
				default: begin
					mcand_q          <= gyro_rate;
					mplier_q         <= tq_q;
					scaled_q[axis_q] <= gyro_rate;
				end
			endcase
		end

		if (state_q == ST_MUL) begin
			macc_q   <= mul_sum >>> DIGIT_W;
			mlo_q    <= {mul_sum[DIGIT_W-1:0], mlo_q[TQ_W-1:DIGIT_W]};
			mplier_q <= mplier_q >> DIGIT_W;
		end

		if (state_q == ST_FIN) begin
			unique case (op_q)
				OP_TICKS: tq_q <= {macc_q[STAMP_W-1:0], mlo_q[TQ_W-1:STAMP_W]};
				OP_ACCEL: scaled_q[axis_q] <= accel_round;
				default:  inc_q <= $signed({macc_q[28:0], mlo_q[55:32]})
					+ INC_W'(mlo_q[31]);
			endcase
		end

		// next axis moves to the head of the raw line
		if ((state_q == ST_FIN && op_q == OP_ACCEL) || state_q == ST_ACC) begin
			raw_q[0] <= raw_q[1];
			raw_q[1] <= raw_q[2];
		end

		if (load_out) begin
			out_kind_q  <= kind_q;
			out_delta_q <= delta_q;
			for (int i = 0; i < AXES; i++) begin
				out_scaled_q[i] <= scaled_q[i];
				out_ang_q[i]    <= ANGLE_OUT_W'(ang_q[i]);
			end
		end
	end

	assign result.valid       = out_valid_q;
	assign result.kind        = out_kind_q;
	assign result.scaled_x    = out_scaled_q[0];
	assign result.scaled_y    = out_scaled_q[1];
	assign result.scaled_z    = out_scaled_q[2];
	assign result.angle_x     = out_ang_q[0];
	assign result.angle_y     = out_ang_q[1];
	assign result.angle_z     = out_ang_q[2];
	assign result.delta_ticks = out_delta_q;

	`IFSI_ASSERT(a_gyro_unset_zero_delta,
		(accept && frame.action == KIND_GYRO && time_unset_q) |=> (delta_q == '0),
		"gyro beat before any accel beat must see zero delta")
	`IFSI_ASSERT(a_angles_only_in_acc,
		(state_q != ST_ACC) |=> ($stable(ang_q[0]) && $stable(ang_q[1]) && $stable(ang_q[2])),
		"angle accumulator changed outside the accumulate step")
	`IFSI_ASSERT(a_mul_ends_in_fin,
		(state_q == ST_MUL && cnt_q == '0) |=> (state_q == ST_FIN),
		"digit multiplier did not hand off after its last digit")
	`IFSI_ASSERT_ALWAYS(a_result_from_done,
		$rose(result.valid) |-> ($past(state_q) == ST_DONE),
		"result beat raised outside the done step")

endmodule

`default_nettype wire

### bench/imu_frame_scale_integrate_unit_test.sv
// self-checking bench for imu_frame_scale_integrate_unit: directed and random sensor frames,
// results checked field by field against a scoreboard that predicts scaling and integration
// depends on ifsi_pkg, ifsi_if and the rtl of the block
`default_nettype none

module imu_frame_scale_integrate_unit_test;
	import ifsi_pkg::*;

	localparam int HOLD_CYCLES   = 400;
	localparam int STALL_LIMIT   = 3000;
	localparam int DRAIN_TAIL    = 60;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 188;

	localparam longint ANGLE_MAX = (64'sd1 <<< (ANGLE_BITS - 1)) - 64'sd1;
	localparam longint ANGLE_MIN = -ANGLE_MAX - 64'sd1;

	typedef struct packed {
		logic                    action;
		logic signed [RAW_W-1:0] raw_x;
		logic signed [RAW_W-1:0] raw_y;
		logic signed [RAW_W-1:0] raw_z;
		logic [STAMP_W-1:0]      stamp;
	} frame_t;

	typedef struct packed {
		logic                   kind;
		logic [SCALED_W-1:0]    scaled_x;
		logic [SCALED_W-1:0]    scaled_y;
		logic [SCALED_W-1:0]    scaled_z;
		logic [ANGLE_OUT_W-1:0] angle_x;
		logic [ANGLE_OUT_W-1:0] angle_y;
		logic [ANGLE_OUT_W-1:0] angle_z;
		logic [STAMP_W-1:0]     delta;
	} outcome_t;

	class imu_scoreboard;
		logic [ACC_CODE_W-1:0] acc_code  = 2'd1;
		logic [GYR_CODE_W-1:0] gyro_code = 3'd0;
		logic [GRAV_W-1:0]     gravity   = 20'd642689;
		logic [TICK_W-1:0]     tick      = 32'd167772;
		logic [STAMP_W-1:0]    now_stamp  = '0;
		logic [STAMP_W-1:0]    last_stamp = '0;
		bit                    no_stamp_yet = 1'b1;
		longint                angle_acc [3];
		outcome_t              awaited_results [$];
		int accel_frames, gyro_frames, clamps, results_seen, mismatches;

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_ACC_RANGE:  acc_code  = val[ACC_CODE_W-1:0];
				REG_GYRO_RANGE: gyro_code = val[GYR_CODE_W-1:0];
				REG_GRAVITY:    gravity   = val[GRAV_W-1:0];
				REG_TICK:       tick      = val[TICK_W-1:0];
				default: ;
			endcase
		endfunction

		function longint acc_gain();
			case (acc_code)
				2'd0: return 64'sd3;
				2'd1: return 64'sd6;
				2'd2: return 64'sd12;
				default: return 64'sd24;
			endcase
		endfunction

		// codes above the 125 dps setting fall back to it
		function longint gyro_gain();
			case (gyro_code)
				3'd0: return 64'sd2000;
				3'd1: return 64'sd1000;
				3'd2: return 64'sd500;
				3'd3: return 64'sd250;
				default: return 64'sd125;
			endcase
		endfunction

		function int pending();
			return awaited_results.size();
		endfunction

		function void note_frame(frame_t f);
			outcome_t o;
			longint raw [3];
			longint rate [3];
			longint gain, hi, lo, inc, sum;
			longint unsigned d64, t64, tq;
			logic [STAMP_W-1:0] dt;
			raw[0] = longint'(f.raw_x);
			raw[1] = longint'(f.raw_y);
			raw[2] = longint'(f.raw_z);
			if (f.action == KIND_ACCEL) begin
				accel_frames++;
				gain = acc_gain() * longint'(gravity);
				// arithmetic shift after adding half gives round half up
				for (int i = 0; i < 3; i++)
					rate[i] = (raw[i] * gain + 64'sd16384) >>> 15;
				last_stamp = no_stamp_yet ? f.stamp : now_stamp;
				no_stamp_yet = 1'b0;
				now_stamp = f.stamp;
				dt = now_stamp - last_stamp;
			end else begin
				gyro_frames++;
				dt = now_stamp - last_stamp;
				d64 = 64'(dt);
				t64 = 64'(tick);
				tq = d64 * t64;
				hi = longint'(tq >> 32);
				lo = longint'(tq & 64'hffff_ffff);
				for (int i = 0; i < 3; i++) begin
					rate[i] = raw[i] * gyro_gain() * 64'sd2;
					inc = rate[i] * hi + ((rate[i] * lo + 64'sd2147483648) >>> 32);
					sum = angle_acc[i] + inc;
					if (sum > ANGLE_MAX) begin
						sum = ANGLE_MAX;
						clamps++;
					end else if (sum < ANGLE_MIN) begin
						sum = ANGLE_MIN;
						clamps++;
					end
					angle_acc[i] = sum;
				end
			end
			o.kind     = f.action;
			o.scaled_x = rate[0][SCALED_W-1:0];
			o.scaled_y = rate[1][SCALED_W-1:0];
			o.scaled_z = rate[2][SCALED_W-1:0];
			o.angle_x  = angle_acc[0][ANGLE_OUT_W-1:0];
			o.angle_y  = angle_acc[1][ANGLE_OUT_W-1:0];
			o.angle_z  = angle_acc[2][ANGLE_OUT_W-1:0];
			o.delta    = dt;
			awaited_results.push_back(o);
		endfunction

		function void compare_field(string name, logic [63:0] want_v, logic [63:0] got_v);
			if (want_v !== got_v) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%s mismatch on result %0d: expected %h, got %h",
						name, results_seen, want_v, got_v);
			end
		endfunction

		function void check_result(outcome_t got);
			outcome_t want;
			results_seen++;
			if (awaited_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d arrived with no frame outstanding", results_seen);
				return;
			end
			want = awaited_results.pop_front();
			compare_field("kind", 64'(want.kind), 64'(got.kind));
			compare_field("scaled_x", 64'(want.scaled_x), 64'(got.scaled_x));
			compare_field("scaled_y", 64'(want.scaled_y), 64'(got.scaled_y));
			compare_field("scaled_z", 64'(want.scaled_z), 64'(got.scaled_z));
			compare_field("angle_x", 64'(want.angle_x), 64'(got.angle_x));
			compare_field("angle_y", 64'(want.angle_y), 64'(got.angle_y));
			compare_field("angle_z", 64'(want.angle_z), 64'(got.angle_z));
			compare_field("delta_ticks", 64'(want.delta), 64'(got.delta));
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	ifsi_frame_if  frame_ch ();
	ifsi_result_if result_ch ();

	imu_frame_scale_integrate_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.frame     (frame_ch),
		.result    (result_ch)
	);

	imu_scoreboard      board = new();
	bit                 idle_on = 1'b1;
	bit                 hold_req = 1'b0;
	int                 quiet_cycles = 0;
	int                 settings_applied = 0;
	logic [STAMP_W-1:0] stamp_trail = '0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// beat monitor: both channels sampled at the edge, before this edge's updates land
	always @(posedge clk) begin
		frame_t   seen;
		outcome_t got;
		if (arst_n) begin
			if (frame_ch.valid && frame_ch.ready) begin
				seen.action = frame_ch.action;
				seen.raw_x  = frame_ch.raw_x;
				seen.raw_y  = frame_ch.raw_y;
				seen.raw_z  = frame_ch.raw_z;
				seen.stamp  = frame_ch.stamp;
				board.note_frame(seen);
			end
			if (result_ch.valid && result_ch.ready) begin
				got.kind     = result_ch.kind;
				got.scaled_x = result_ch.scaled_x;
				got.scaled_y = result_ch.scaled_y;
				got.scaled_z = result_ch.scaled_z;
				got.angle_x  = result_ch.angle_x;
				got.angle_y  = result_ch.angle_y;
				got.angle_z  = result_ch.angle_z;
				got.delta    = result_ch.delta_ticks;
				board.check_result(got);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (frame_ch.valid && frame_ch.ready) || (result_ch.valid && result_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("no beat on either channel for %0d cycles", quiet_cycles);
			$display("FAIL imu_frame_scale_integrate_unit");
			$finish;
		end
	end

	// result side: random gaps per beat, one long hold when asked
	initial begin
		int gap;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				gap = HOLD_CYCLES;
			end else begin
				gap = idle_on ? int'($urandom_range(0, 12)) : 0;
			end
			if (gap > 0) begin
				result_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
		end
	end

	task automatic send_frame(input frame_t f);
		int gap;
		gap = idle_on ? int'($urandom_range(0, 12)) : 0;
		if (gap > 0) begin
			frame_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		frame_ch.valid  <= 1'b1;
		frame_ch.action <= f.action;
		frame_ch.raw_x  <= f.raw_x;
		frame_ch.raw_y  <= f.raw_y;
		frame_ch.raw_z  <= f.raw_z;
		frame_ch.stamp  <= f.stamp;
		do @(posedge clk); while (!frame_ch.ready);
	endtask

	task automatic drain();
		frame_ch.valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		board.set_reg(idx, val);
	endtask

	task automatic write_config(input logic [ACC_CODE_W-1:0] acc, input logic [GYR_CODE_W-1:0] gyr,
			input logic [GRAV_W-1:0] grav, input logic [TICK_W-1:0] tick);
		cfg_we <= 1'b1;
		put_reg(REG_ACC_RANGE, CFG_DATA_W'(acc));
		put_reg(REG_GYRO_RANGE, CFG_DATA_W'(gyr));
		put_reg(REG_GRAVITY, CFG_DATA_W'(grav));
		put_reg(REG_TICK, CFG_DATA_W'(tick));
		cfg_we <= 1'b0;
		settings_applied++;
	endtask

	function automatic frame_t mk_frame(logic action, int x, int y, int z, logic [STAMP_W-1:0] st);
		frame_t f;
		f.action = action;
		f.raw_x  = RAW_W'(x);
		f.raw_y  = RAW_W'(y);
		f.raw_z  = RAW_W'(z);
		f.stamp  = st;
		return f;
	endfunction

	function automatic logic signed [RAW_W-1:0] pick_raw();
		logic [31:0] r;
		r = $urandom();
		case (r[31:28])
			4'd0: return 16'sh8000;
			4'd1: return 16'sh7fff;
			4'd2: return 16'sh0000;
			4'd3: return 16'shffff;
			default: return r[RAW_W-1:0];
		endcase
	endfunction

	function automatic frame_t random_frame();
		frame_t f;
		logic [31:0] r;
		r = $urandom();
		f.action = r[0] ? KIND_GYRO : KIND_ACCEL;
		f.raw_x  = pick_raw();
		f.raw_y  = pick_raw();
		f.raw_z  = pick_raw();
		// small forward steps, repeated stamps, random jumps and stamps near the wrap point, in equal shares
		case (r[2:1])
			2'd0: f.stamp = r[31:8];
			2'd1: f.stamp = stamp_trail + STAMP_W'($urandom_range(0, 2000));
			2'd2: f.stamp = 24'hffffff - STAMP_W'($urandom_range(0, 50));
			default: f.stamp = stamp_trail;
		endcase
		if (f.action == KIND_ACCEL)
			stamp_trail = f.stamp;
		return f;
	endfunction

	initial begin
		logic [GRAV_W-1:0] grav;
		logic [TICK_W-1:0] tick;
		arst_n          <= 1'b0;
		cfg_we          <= 1'b0;
		cfg_index       <= '0;
		cfg_wdata       <= '0;
		frame_ch.valid  <= 1'b0;
		frame_ch.action <= KIND_ACCEL;
		frame_ch.raw_x  <= '0;
		frame_ch.raw_y  <= '0;
		frame_ch.raw_z  <= '0;
		frame_ch.stamp  <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: gyro before any stamp, first stamp, stamp wrap
		send_frame(mk_frame(KIND_GYRO, 32767, -32768, 0, 24'h123456));
		send_frame(mk_frame(KIND_ACCEL, 32767, -32768, 0, 24'hfffff0));
		send_frame(mk_frame(KIND_ACCEL, -1, 1, -32768, 24'h000010));
		send_frame(mk_frame(KIND_GYRO, 32767, -32768, 1, 24'h000000));
		send_frame(mk_frame(KIND_GYRO, -1, 0, 32767, 24'hffffff));
		drain();

		// top of every range, unused gyro code: accumulators run into both limits
		write_config(2'd3, 3'd7, 20'hfffff, 32'hffffffff);
		send_frame(mk_frame(KIND_ACCEL, 32767, -32768, -1, 24'h000000));
		send_frame(mk_frame(KIND_ACCEL, 1, -1, 0, 24'hffffff));
		send_frame(mk_frame(KIND_GYRO, 32767, 32767, -32768, 24'h000000));
		send_frame(mk_frame(KIND_GYRO, 32767, 32767, -32768, 24'h000000));
		send_frame(mk_frame(KIND_GYRO, -32768, -32768, 32767, 24'h000000));
		send_frame(mk_frame(KIND_GYRO, 0, -1, 1, 24'h000000));
		drain();

		// settings that put both roundings exactly on a half
		write_config(2'd0, 3'd4, 20'd16384, 32'h40000000);
		send_frame(mk_frame(KIND_ACCEL, 1, -1, 3, 24'd100));
		send_frame(mk_frame(KIND_ACCEL, 1, -1, 0, 24'd101));
		send_frame(mk_frame(KIND_GYRO, 1, -1, 3, 24'd0));
		send_frame(mk_frame(KIND_GYRO, -1, 1, 32767, 24'd0));
		drain();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			grav = (p == 0) ? '0 : (p == 1) ? '1 : GRAV_W'($urandom());
			if (p == 0)
				tick = '0;
			else if (p == 1)
				tick = '1;
			else if ($urandom_range(0, 3) == 0)
				tick = $urandom();
			else
				tick = TICK_W'($urandom_range(0, 1 << 20));
			write_config(ACC_CODE_W'(p), GYR_CODE_W'(p), grav, tick);
			idle_on = (p % 3 != 2);
			if (p == 4)
				hold_req = 1'b1;
			repeat (PHASE_ITEMS) send_frame(random_frame());
			drain();
		end

		repeat (DRAIN_TAIL) @(posedge clk);
		$display("%0d frames checked (%0d accelerometer, %0d gyro) under %0d register settings",
			board.results_seen, board.accel_frames, board.gyro_frames, settings_applied);
		$display("%0d clamped angle updates, %0d mismatches", board.clamps, board.mismatches);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("PASS imu_frame_scale_integrate_unit");
		else
			$display("FAIL imu_frame_scale_integrate_unit");
		$finish;
	end

endmodule

`default_nettype wire
